// File: sv/nvcvb_pkg.sv
// shared constants and types for the nvme command validate and build unit
`default_nettype none
package nvcvb_pkg;

	typedef logic [2:0] status_t;
	typedef logic [1:0] opcode_t;
	typedef logic [2:0] cfg_index_t;

	// result status codes, first failing check wins
	localparam status_t ST_OK          = 3'd0;
	localparam status_t ST_MISSING     = 3'd1;
	localparam status_t ST_MISALIGNED  = 3'd2;
	localparam status_t ST_BAD_COUNT   = 3'd3;
	localparam status_t ST_BEYOND_NS   = 3'd4;
	localparam status_t ST_UNCONFIRMED = 3'd5;
	localparam status_t ST_PROTECTED   = 3'd6;

	// nvme opcodes
	localparam opcode_t OPC_NONE  = 2'd0;
	localparam opcode_t OPC_WRITE = 2'd1;
	localparam opcode_t OPC_READ  = 2'd2;

	// register indexes
	localparam cfg_index_t CFG_LBA_SIZE    = 3'd0;
	localparam cfg_index_t CFG_NS_SIZE     = 3'd1;
	localparam cfg_index_t CFG_TIMEOUT     = 3'd2;
	localparam cfg_index_t CFG_WRITE_CONF  = 3'd3;
	localparam cfg_index_t CFG_NS_PRESENT  = 3'd4;

	localparam int unsigned MIN_LBA_LOG2    = 9;
	localparam int unsigned MAX_BLOCKS      = 65536;
	localparam int unsigned PROTECTED_BYTES = 1024 * 1024;
	localparam logic [16:0] LBA_RESET       = 17'd512;

endpackage
`default_nettype wire

// File: sv/nvme_io_command_validate_build_unit.sv
// top level: four stage pipeline that checks nvme read/write requests and builds commands
//
// usage:
//   requests enter on the input channel (in_valid / in_stall), one word per
//   request; finished commands leave on the output channel (out_valid /
//   out_stall) in request order, one word per request.
//   namespace settings are written through the cfg channel (cfg_valid /
//   cfg_ready, cfg_index, cfg_data) while the pipe is empty; cfg_ready is
//   always high and writes to unknown indexes are dropped.
// stages: the word passes four register stages, the last one being the output register.
// throughput: one request per cycle unless the output stalls; the lba size is a
//   power of two, so all block math is a barrel shift by log2(lba size).
// reset: the pipe empties and settings return to lba size 512, all else zero.
// stall: a stalled output word holds; each stage keeps its word while the stage
//   after it is full and held, so in_stall rises only once the pipe backs up.
`default_nettype none
module nvme_io_command_validate_build_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire nvcvb_pkg::cfg_index_t  cfg_index,
	input  wire logic [63:0]            cfg_data,
	// requests
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   command,
	input  wire logic [31:0]            namespace_id,
	input  wire logic [31:0]            transfer_bytes,
	input  wire logic [63:0]            start_lba,
	// commands
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output nvcvb_pkg::status_t          plan_status,
	output nvcvb_pkg::opcode_t          command_opcode,
	output logic [31:0]                 namespace_out,
	output logic [31:0]                 data_length,
	output logic [31:0]                 dword10_lba_low,
	output logic [31:0]                 dword11_lba_high,
	output logic [15:0]                 dword12_count_minus_one,
	output logic [31:0]                 timeout_out,
	output logic [63:0]                 start_byte_offset,
	output logic [16:0]                 total_blocks
);
	import nvcvb_pkg::*;

	// settings
	logic [16:0] lba_size_q;
	logic [63:0] ns_size_q;
	logic [31:0] timeout_q;
	logic        write_conf_q;
	logic        ns_present_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lba_size_q   <= LBA_RESET;
			ns_size_q    <= '0;
			timeout_q    <= '0;
			write_conf_q <= 1'b0;
			ns_present_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LBA_SIZE:   lba_size_q   <= cfg_data[16:0];
				CFG_NS_SIZE:    ns_size_q    <= cfg_data;
				CFG_TIMEOUT:    timeout_q    <= cfg_data[31:0];
				CFG_WRITE_CONF: write_conf_q <= cfg_data[0];
				CFG_NS_PRESENT: ns_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// lba size decode: log2 minus 9, and shift amount
	logic       lba_ok;
	logic [2:0] lba_sh;
	logic [4:0] lba_amt;

	always_comb begin
		lba_sh = '0;
		for (int i = 0; i < 8; i++) begin
			if (lba_size_q[MIN_LBA_LOG2 + i]) lba_sh = 3'(i);
		end
		lba_ok  = (lba_size_q[8:0] == '0) && (lba_size_q != '0)
			&& ((lba_size_q & (lba_size_q - 17'd1)) == '0);
		lba_amt = {2'b00, lba_sh} + 5'(MIN_LBA_LOG2);
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: missing fields, alignment, block count
	status_t     st_s1;
	logic        cmd_s1;
	logic [31:0] nsid_s1;
	logic [31:0] bytes_s1;
	logic [63:0] slba_s1;
	logic [22:0] blocks_s1;

	logic        missing_c;
	logic [31:0] byte_mask_c;
	logic [31:0] blocks_wide_c;

	always_comb begin
		missing_c     = !ns_present_q || (namespace_id == '0) || (transfer_bytes == '0)
			|| (timeout_q == '0);
		byte_mask_c   = (32'd1 << lba_amt) - 32'd1;
		blocks_wide_c = transfer_bytes >> lba_amt;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			if (missing_c) st_s1 <= ST_MISSING;
			else if (!lba_ok || ((transfer_bytes & byte_mask_c) != '0)) st_s1 <= ST_MISALIGNED;
			else st_s1 <= ST_OK;
			cmd_s1    <= command;
			nsid_s1   <= namespace_id;
			bytes_s1  <= transfer_bytes;
			slba_s1   <= start_lba;
			blocks_s1 <= blocks_wide_c[22:0];
		end
	end

	// stage 2: count limits, namespace fit, namespace blocks, byte offset
	status_t     st_s2;
	logic        cmd_s2;
	logic [31:0] nsid_s2;
	logic [31:0] bytes_s2;
	logic [63:0] slba_s2;
	logic [16:0] blocks_s2;
	logic [54:0] ns_blocks_s2;
	logic [63:0] offset_s2;

	logic        bad_count_c;
	logic        ns_bad_c;
	logic [64:0] end_sum_c;
	logic [63:0] ns_mask_c;
	logic [63:0] ns_blocks_wide_c;

	always_comb begin
		end_sum_c        = {1'b0, slba_s1} + 65'(blocks_s1);
		bad_count_c      = (blocks_s1 == '0) || (blocks_s1 > 23'(MAX_BLOCKS)) || end_sum_c[64];
		ns_mask_c        = (64'd1 << lba_amt) - 64'd1;
		ns_bad_c         = (ns_size_q < 64'(lba_size_q)) || ((ns_size_q & ns_mask_c) != '0);
		ns_blocks_wide_c = ns_size_q >> lba_amt;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			if (st_s1 != ST_OK) st_s2 <= st_s1;
			else if (bad_count_c) st_s2 <= ST_BAD_COUNT;
			else if (ns_bad_c) st_s2 <= ST_BEYOND_NS;
			else st_s2 <= ST_OK;
			cmd_s2       <= cmd_s1;
			nsid_s2      <= nsid_s1;
			bytes_s2     <= bytes_s1;
			slba_s2      <= slba_s1;
			blocks_s2    <= blocks_s1[16:0];
			ns_blocks_s2 <= ns_blocks_wide_c[54:0];
			offset_s2    <= slba_s1 << lba_amt;
		end
	end

	// stage 3: range inside namespace, write permission, protected prefix
	status_t     st_s3;
	logic        cmd_s3;
	logic [31:0] nsid_s3;
	logic [31:0] bytes_s3;
	logic [63:0] slba_s3;
	logic [16:0] blocks_s3;
	logic [63:0] offset_s3;

	logic        start_out_c;
	logic [54:0] room_c;
	logic        range_bad_c;

	always_comb begin
		start_out_c = slba_s2 >= 64'(ns_blocks_s2);
		room_c      = ns_blocks_s2 - slba_s2[54:0];
		range_bad_c = start_out_c || (55'(blocks_s2) > room_c);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			if (st_s2 != ST_OK) st_s3 <= st_s2;
			else if (range_bad_c) st_s3 <= ST_BEYOND_NS;
			else if (cmd_s2 && !write_conf_q) st_s3 <= ST_UNCONFIRMED;
			else if (cmd_s2 && (offset_s2 < 64'(PROTECTED_BYTES))) st_s3 <= ST_PROTECTED;
			else st_s3 <= ST_OK;
			cmd_s3    <= cmd_s2;
			nsid_s3   <= nsid_s2;
			bytes_s3  <= bytes_s2;
			slba_s3   <= slba_s2;
			blocks_s3 <= blocks_s2;
			offset_s3 <= offset_s2;
		end
	end

	// stage 4: output word, command fields zero on error
	logic ok_c;
	assign ok_c = (st_s3 == ST_OK);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			plan_status             <= st_s3;
			command_opcode          <= !ok_c ? OPC_NONE : (cmd_s3 ? OPC_WRITE : OPC_READ);
			namespace_out           <= ok_c ? nsid_s3 : '0;
			data_length             <= ok_c ? bytes_s3 : '0;
			dword10_lba_low         <= ok_c ? slba_s3[31:0] : '0;
			dword11_lba_high        <= ok_c ? slba_s3[63:32] : '0;
			dword12_count_minus_one <= ok_c ? 16'(blocks_s3 - 17'd1) : '0;
			timeout_out             <= ok_c ? timeout_q : '0;
			start_byte_offset       <= ok_c ? offset_s3 : '0;
			total_blocks            <= ok_c ? blocks_s3 : '0;
		end
	end

	// checks
	a_ok_has_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (plan_status == ST_OK) |-> (command_opcode != OPC_NONE)
			&& (total_blocks != '0))
		else $error("accepted command without opcode or blocks");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (plan_status != ST_OK) |-> (command_opcode == OPC_NONE)
			&& (total_blocks == '0) && (start_byte_offset == '0))
		else $error("error word carries command fields");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty first stage");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && out_stall |=> v_s4 && $stable(plan_status) && $stable(start_byte_offset))
		else $error("stalled output word changed");

	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (plan_status == ST_OK) |-> (total_blocks <= 17'(MAX_BLOCKS)))
		else $error("accepted command exceeds block limit");

endmodule
`default_nettype wire

// File: tb/nvcvb_command_checker.sv
// checker for the nvme command unit: predicts each command from its request and compares
module nvcvb_command_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire nvcvb_pkg::cfg_index_t cfg_index,
	input  wire logic [63:0]           cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  command,
	input  wire logic [31:0]           namespace_id,
	input  wire logic [31:0]           transfer_bytes,
	input  wire logic [63:0]           start_lba,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire nvcvb_pkg::status_t    plan_status,
	input  wire nvcvb_pkg::opcode_t    command_opcode,
	input  wire logic [31:0]           namespace_out,
	input  wire logic [31:0]           data_length,
	input  wire logic [31:0]           dword10_lba_low,
	input  wire logic [31:0]           dword11_lba_high,
	input  wire logic [15:0]           dword12_count_minus_one,
	input  wire logic [31:0]           timeout_out,
	input  wire logic [63:0]           start_byte_offset,
	input  wire logic [16:0]           total_blocks,
	output int                         fail_count,
	output int                         pending
);
	import nvcvb_pkg::*;

	localparam logic [63:0] MIN_LBA = 64'd1 << MIN_LBA_LOG2;

	typedef struct packed {
		status_t     status;
		opcode_t     opcode;
		logic [31:0] nsid;
		logic [31:0] length;
		logic [31:0] lba_low;
		logic [31:0] lba_high;
		logic [15:0] count_m1;
		logic [31:0] timeout;
		logic [63:0] start_offset;
		logic [16:0] blocks;
	} cmd_word_t;

	// private copy of the namespace settings
	logic [16:0] lba_size_q   = LBA_RESET;
	logic [63:0] ns_size_q    = '0;
	logic [31:0] timeout_q    = '0;
	logic        write_conf_q = 1'b0;
	logic        ns_present_q = 1'b0;

	cmd_word_t expected_cmds[$];
	int        results_seen = 0;

	// checks in fixed order, first failing one sets the status
	function automatic cmd_word_t build_command(input logic is_write, input logic [31:0] nsid,
			input logic [31:0] bytes, input logic [63:0] slba);
		cmd_word_t w;
		logic [63:0] lba;
		logic [63:0] blocks;
		logic [63:0] ns_blocks;
		w = '0;
		lba = 64'(lba_size_q);
		blocks = '0;
		if (!ns_present_q || nsid == '0 || bytes == '0 || timeout_q == '0) begin
			w.status = ST_MISSING;
		end else if (lba < MIN_LBA || (lba & (lba - 64'd1)) != '0 || 64'(bytes) % lba != '0) begin
			w.status = ST_MISALIGNED;
		end else begin
			blocks = 64'(bytes) / lba;
			if (blocks == '0 || blocks > 64'(MAX_BLOCKS) || slba > ~64'd0 - blocks) begin
				w.status = ST_BAD_COUNT;
			end else if (ns_size_q < lba || ns_size_q % lba != '0) begin
				w.status = ST_BEYOND_NS;
			end else begin
				ns_blocks = ns_size_q / lba;
				if (slba >= ns_blocks || blocks > ns_blocks - slba) begin
					w.status = ST_BEYOND_NS;
				end else if (is_write && !write_conf_q) begin
					w.status = ST_UNCONFIRMED;
				end else if (is_write && slba * lba < 64'(PROTECTED_BYTES)) begin
					w.status = ST_PROTECTED;
				end else begin
					w.status = ST_OK;
				end
			end
		end
		// error results carry nothing but the status
		if (w.status == ST_OK) begin
			w.opcode       = is_write ? OPC_WRITE : OPC_READ;
			w.nsid         = nsid;
			w.length       = bytes;
			w.lba_low      = slba[31:0];
			w.lba_high     = slba[63:32];
			w.count_m1     = 16'(blocks - 64'd1);
			w.timeout      = timeout_q;
			w.start_offset = slba * lba;
			w.blocks       = 17'(blocks);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string text);
		$display("mismatch at result %0d: %s", results_seen, text);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	// follow settings writes, queue predictions, compare finished commands
	always @(posedge clk or negedge arst_n) begin : watch
		cmd_word_t want;
		if (!arst_n) begin
			lba_size_q   = LBA_RESET;
			ns_size_q    = '0;
			timeout_q    = '0;
			write_conf_q = 1'b0;
			ns_present_q = 1'b0;
			expected_cmds.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LBA_SIZE:   lba_size_q   = cfg_data[16:0];
					CFG_NS_SIZE:    ns_size_q    = cfg_data;
					CFG_TIMEOUT:    timeout_q    = cfg_data[31:0];
					CFG_WRITE_CONF: write_conf_q = cfg_data[0];
					CFG_NS_PRESENT: ns_present_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_cmds.push_back(build_command(command, namespace_id, transfer_bytes,
					start_lba));
			end
			if (out_valid && !out_stall) begin
				if (expected_cmds.size() == 0) begin
					report_mismatch("command word with no request outstanding");
				end else begin
					want = expected_cmds.pop_front();
					check_field("plan_status", 64'(plan_status), 64'(want.status));
					check_field("command_opcode", 64'(command_opcode), 64'(want.opcode));
					check_field("namespace_out", 64'(namespace_out), 64'(want.nsid));
					check_field("data_length", 64'(data_length), 64'(want.length));
					check_field("dword10_lba_low", 64'(dword10_lba_low), 64'(want.lba_low));
					check_field("dword11_lba_high", 64'(dword11_lba_high), 64'(want.lba_high));
					check_field("dword12_count_minus_one", 64'(dword12_count_minus_one),
						64'(want.count_m1));
					check_field("timeout_out", 64'(timeout_out), 64'(want.timeout));
					check_field("start_byte_offset", start_byte_offset, want.start_offset);
					check_field("total_blocks", 64'(total_blocks), 64'(want.blocks));
				end
				results_seen++;
			end
		end
		pending = expected_cmds.size();
	end

endmodule

// File: tb/nvme_io_command_validate_build_unit_tb.sv
// testbench top: drives requests and namespace settings into the command unit, gives the verdict
module nvme_io_command_validate_build_unit_tb;
	import nvcvb_pkg::*;

	localparam int   PIPE_LATENCY = 4;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam logic DIR_READ     = 1'b0;
	localparam logic DIR_WRITE    = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] nsid;
		logic [31:0] bytes;
		logic [63:0] slba;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_index_t  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [31:0] namespace_id;
	logic [31:0] transfer_bytes;
	logic [63:0] start_lba;
	logic        out_valid;
	logic        out_stall;
	status_t     plan_status;
	opcode_t     command_opcode;
	logic [31:0] namespace_out;
	logic [31:0] data_length;
	logic [31:0] dword10_lba_low;
	logic [31:0] dword11_lba_high;
	logic [15:0] dword12_count_minus_one;
	logic [31:0] timeout_out;
	logic [63:0] start_byte_offset;
	logic [16:0] total_blocks;

	int fail_count;
	int pending;
	int cycle_count = 0;

	logic        sender_gaps;
	logic        receiver_gaps;
	logic        long_hold_req;
	logic [16:0] shadow_lba;
	logic [63:0] shadow_ns;

	nvme_io_command_validate_build_unit dut (.*);

	nvcvb_command_checker checker_i (.*);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int hold_cycles;
		bit hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_done) begin
				out_stall = 1'b1;
				for (hold_cycles = 0; hold_cycles < 80; hold_cycles++) @(negedge clk);
				out_stall = 1'b0;
				hold_done = 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// all five registers, then a write to an unused index that must be dropped
	task automatic apply_settings(input logic [63:0] lba_w, input logic [63:0] ns_w,
			input logic [63:0] tmo_w, input logic [63:0] conf_w, input logic [63:0] pres_w);
		write_reg(CFG_LBA_SIZE, lba_w);
		write_reg(CFG_NS_SIZE, ns_w);
		write_reg(CFG_TIMEOUT, tmo_w);
		write_reg(CFG_WRITE_CONF, conf_w);
		write_reg(CFG_NS_PRESENT, pres_w);
		write_reg(cfg_index_t'(CFG_NS_PRESENT + $urandom_range(1, 3)), {$urandom, $urandom});
		shadow_lba = lba_w[16:0];
		shadow_ns  = ns_w;
	endtask

	// one word on the request channel, held until accepted
	task automatic send_request(input logic cmd, input logic [31:0] nsid,
			input logic [31:0] bytes, input logic [63:0] slba);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		command        = cmd;
		namespace_id   = nsid;
		transfer_bytes = bytes;
		start_lba      = slba;
		in_valid       = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// sender pauses until every command is back
	task automatic wait_all_done();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// mostly well-formed requests shaped to the current namespace, some noise
	function automatic req_t make_request();
		req_t r;
		logic [63:0] lba;
		logic [63:0] ns_blocks;
		logic [63:0] blocks;
		logic [63:0] span;
		r.command = 1'($urandom_range(0, 1));
		r.nsid = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(1, 16));
		lba = 64'(shadow_lba);
		if (lba < 64'd512 || (lba & (lba - 64'd1)) != '0) lba = 64'd512;
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 3) == 0) r.nsid = '0;
			case ($urandom_range(0, 3))
				0: r.bytes = '0;
				1: r.bytes = $urandom;
				default: r.bytes = 32'(64'($urandom_range(1, 64)) * lba);
			endcase
			if ($urandom_range(0, 1) == 0) r.slba = {$urandom, $urandom};
			else r.slba = ~64'd0 - 64'($urandom_range(0, 70000));
			return r;
		end
		case ($urandom_range(0, 9))
			6, 7: blocks = 64'($urandom_range(1, 512));
			8: blocks = 64'($urandom_range(1, MAX_BLOCKS));
			9: blocks = 64'($urandom_range(MAX_BLOCKS - 1, MAX_BLOCKS + 1));
			default: blocks = 64'($urandom_range(1, 8));
		endcase
		if (blocks * lba > 64'hFFFF_FFFF) blocks = 64'hFFFF_FFFF / lba;
		r.bytes = 32'(blocks * lba);
		if ($urandom_range(0, 19) == 0) r.bytes = r.bytes + 32'($urandom_range(1, 511));
		// start block: inside the namespace, on its edges, or in the protected prefix
		ns_blocks = shadow_ns / lba;
		span = (ns_blocks > blocks) ? ns_blocks - blocks : 64'd0;
		case ($urandom_range(0, 9))
			0: r.slba = span;
			1: r.slba = span + 64'd1;
			2: r.slba = ns_blocks;
			3: r.slba = 64'($urandom) % (64'(PROTECTED_BYTES) / lba + 64'd1);
			default: r.slba = {$urandom, $urandom} % (span + 64'd1);
		endcase
		return r;
	endfunction

	task automatic run_requests(input int count, input logic idle_ok);
		req_t r;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				sender_gaps   = idle_ok && $urandom_range(0, 3) != 0;
				receiver_gaps = idle_ok && $urandom_range(0, 3) != 0;
			end
			r = make_request();
			send_request(r.command, r.nsid, r.bytes, r.slba);
		end
	endtask

	task automatic random_settings();
		logic [63:0] lba_w;
		logic [63:0] ns_w;
		lba_w = 64'd1 << $urandom_range(MIN_LBA_LOG2, 16);
		if ($urandom_range(0, 4) == 0) lba_w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ns_w = {$urandom, $urandom};
			1: ns_w = {$urandom, $urandom} & ~(64'(lba_w[16:0]) - 64'd1);
			default: ns_w = 64'($urandom_range(1, 1 << 22)) * 64'(lba_w[16:0]);
		endcase
		apply_settings(lba_w, ns_w, ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom},
			64'($urandom_range(0, 1)), 64'($urandom_range(0, 5) != 0));
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_LBA_SIZE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		command        = DIR_READ;
		namespace_id   = '0;
		transfer_bytes = '0;
		start_lba      = '0;
		sender_gaps    = 1'b0;
		receiver_gaps  = 1'b0;
		long_hold_req  = 1'b0;
		shadow_lba     = LBA_RESET;
		shadow_ns      = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// settings still at reset: no namespace, every request lacks a field
		run_requests(6, 1'b1);
		wait_all_done();

		// directed corners on a 1 GiB namespace of 512-byte blocks
		apply_settings(64'd512, 64'd1 << 30, 64'd1000, 64'd1, 64'd1);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		send_request(DIR_READ, 32'd1, 32'd512, 64'd0);
		send_request(DIR_READ, 32'hFFFF_FFFF, 32'd4096, 64'd100);
		send_request(DIR_READ, 32'd0, 32'd512, 64'd0);
		send_request(DIR_READ, 32'd1, 32'd0, 64'd0);
		send_request(DIR_READ, 32'd1, 32'd513, 64'd0);
		send_request(DIR_READ, 32'd1, 32'hFFFF_FFFF, 64'd0);
		send_request(DIR_READ, 32'd1, 32'hFFFF_FE00, 64'd0);
		send_request(DIR_READ, 32'd1, 32'h0200_0000, 64'd0);
		send_request(DIR_READ, 32'd1, 32'h0200_0200, 64'd0);
		send_request(DIR_READ, 32'd1, 32'd512, ~64'd0);
		send_request(DIR_READ, 32'd1, 32'd512, ~64'd0 - 64'd1);
		send_request(DIR_READ, 32'd1, 32'd512, 64'd2097151);
		send_request(DIR_READ, 32'd1, 32'd1024, 64'd2097151);
		send_request(DIR_READ, 32'd1, 32'd512, 64'd2097152);
		send_request(DIR_READ, 32'd7, 32'h0200_0000, 64'd2097152 - 64'd65536);
		send_request(DIR_WRITE, 32'd1, 32'd512, 64'd0);
		send_request(DIR_WRITE, 32'd1, 32'd512, 64'd2047);
		send_request(DIR_WRITE, 32'd1, 32'd512, 64'd2048);
		send_request(DIR_WRITE, 32'd0, 32'd512, 64'd4096);
		send_request(DIR_WRITE, 32'd1, 32'd512, ~64'd0);
		run_requests(100, 1'b1);
		wait_all_done();

		// 4 KiB blocks with junk above the register widths, writes not confirmed
		apply_settings(64'hFFFF_FFFF_FFFE_1000, 64'd1 << 40, ~64'd0, 64'hFFFF_FFFF_FFFF_FFFE,
			~64'd0);
		run_requests(60, 1'b1);
		// receiver holds off while requests keep coming, so the pipe backs up
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		long_hold_req = 1'b1;
		run_requests(40, 1'b0);
		wait_all_done();
		run_requests(60, 1'b1);
		wait_all_done();

		// largest block size on the largest namespace
		apply_settings(64'd65536, 64'hFFFF_FFFF_FFFF_0000, 64'd1, 64'd1, 64'd1);
		run_requests(100, 1'b1);
		wait_all_done();

		// block sizes that are zero, too small, not a power of two, or all ones
		apply_settings(64'd0, 64'd1 << 30, 64'd50, 64'd1, 64'd1);
		run_requests(30, 1'b1);
		wait_all_done();
		apply_settings(64'h1_FFFF, 64'd1 << 30, 64'd50, 64'd1, 64'd1);
		run_requests(30, 1'b1);
		wait_all_done();
		apply_settings(64'd768, 64'd1 << 30, 64'd50, 64'd1, 64'd1);
		run_requests(25, 1'b1);
		wait_all_done();
		apply_settings(64'd256, 64'd1 << 30, 64'd50, 64'd1, 64'd1);
		run_requests(25, 1'b1);
		wait_all_done();

		// namespace sizes that are not whole blocks or smaller than one
		apply_settings(64'd512, 64'd1000, 64'd50, 64'd1, 64'd1);
		run_requests(30, 1'b1);
		wait_all_done();
		apply_settings(64'd1024, ~64'd0, 64'd50, 64'd1, 64'd1);
		run_requests(30, 1'b1);
		wait_all_done();
		apply_settings(64'd512, 64'd256, 64'd50, 64'd1, 64'd1);
		run_requests(20, 1'b1);
		wait_all_done();

		// no namespace named, then zero timeout
		apply_settings(64'd512, 64'd1 << 30, 64'd50, 64'd1, 64'd0);
		run_requests(30, 1'b1);
		wait_all_done();
		apply_settings(64'd512, 64'd1 << 30, 64'd0, 64'd1, 64'd1);
		run_requests(30, 1'b1);
		wait_all_done();

		// small namespace where the protected first MiB matters
		apply_settings(64'd1024, 64'd4 << 20, 64'hFFFF_FFFF_0000_0001, 64'd1, 64'd1);
		run_requests(110, 1'b1);
		wait_all_done();

		for (int p = 0; p < 4; p++) begin
			random_settings();
			run_requests(75, 1'b1);
			wait_all_done();
		end

		// last part runs with no idling
		apply_settings(64'd2048, 64'd1 << 33, 64'd30000, 64'd1, 64'd1);
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		run_requests(100, 1'b0);
		wait_all_done();

		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
